[design/wgm_pkg.sv]
// Package for the wildcard glob matcher.
// Character codes, register indexes, fixed field widths and the queue status struct; no dependencies.
`default_nettype none
package wgm_pkg;
  localparam int unsigned CHAR_W = 16;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned IDX_W  = 3;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 16'h002A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 16'h003F;

  localparam logic [IDX_W-1:0] CFG_LEN    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_WORD_A = 3'd1;
  localparam logic [IDX_W-1:0] CFG_WORD_B = 3'd2;
  localparam logic [IDX_W-1:0] CFG_WORD_C = 3'd3;
  localparam logic [IDX_W-1:0] CFG_WORD_D = 3'd4;

  typedef struct packed {
    logic full;
    logic empty;
  } wgm_qstat_t;
endpackage
`default_nettype wire

[design/wgm_if.sv]
// Stream interfaces for the text characters and the match results.
// Depends on wgm_pkg for field widths.
`default_nettype none
interface wgm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wgm_pkg::CHAR_W-1:0]  text_char;
  logic                        last_char;
  logic                        empty_text;
  modport source (output valid, output text_char, output last_char, output empty_text,
                  input ready);
  modport sink   (input valid, input text_char, input last_char, input empty_text,
                  output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic text_done;
  modport source (output valid, output matched, output text_done, input ready);
  modport sink   (input valid, input matched, input text_done, output ready);
endinterface
`default_nettype wire

[design/wildcard_glob_matcher.sv]
// An accepted beat is held in the queue, then its result is registered in the result register.
// Throughput: one character per cycle while the result sink is ready; the whole position set
// is updated at once by the back end, with a two-entry queue decoupling it from the front end.
// Reset (rst_n low, synchronous): pattern registers cleared, position set back to
// the start state, queue and result register emptied.
`default_nettype none
module wildcard_glob_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [wgm_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [wgm_pkg::WORD_W-1:0]     cfg_data,
  wgm_in_if.sink                              in_beat,
  wgm_out_if.source                           out_beat
);
  logic [wgm_pkg::LEN_W-1:0]  len_r;
  logic [wgm_pkg::CHAR_W-1:0] pat_r [PATTERN_MAX];
  logic [wgm_pkg::LEN_W-1:0]  eff_len;
  logic [PATTERN_MAX-1:0]     star;
  logic                       push;
  logic                       pop;
  logic [PATTERN_MAX+1:0]     push_item;
  logic [PATTERN_MAX+1:0]     pop_item;
  wgm_pkg::wgm_qstat_t        qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        pat_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == wgm_pkg::CFG_LEN) begin
        len_r <= cfg_data[wgm_pkg::LEN_W-1:0];
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (cfg_index == wgm_pkg::CFG_WORD_A + wgm_pkg::IDX_W'(i >> 2)) begin
          pat_r[i] <= cfg_data[(i & 3) * wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W];
        end
      end
    end
  end

  assign eff_len = (len_r > wgm_pkg::LEN_W'(PATTERN_MAX)) ? wgm_pkg::LEN_W'(PATTERN_MAX)
                                                          : len_r;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star[i] = (pat_r[i] == wgm_pkg::STAR_CHAR) && (wgm_pkg::LEN_W'(i) < eff_len);
    end
  end

  wgm_front #(.P(PATTERN_MAX)) u_front (
    .in_beat   (in_beat),
    .pat       (pat_r),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  wgm_queue #(.W(PATTERN_MAX + 2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  wgm_back #(.P(PATTERN_MAX)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_len  (eff_len),
    .star     (star),
    .qstat    (qstat),
    .item     (pop_item),
    .pop      (pop),
    .out_beat (out_beat)
  );
endmodule
`default_nettype wire

[design/wgm_front.sv]
// Front end: accepts character beats and classifies them against the pattern.
// Depends on wgm_pkg and wgm_in_if.
`default_nettype none
module wgm_front #(
  parameter int unsigned P = 16
) (
  wgm_in_if.sink                     in_beat,
  input  wire logic [wgm_pkg::CHAR_W-1:0] pat [P],
  input  wire wgm_pkg::wgm_qstat_t   qstat,
  output logic                       push,
  output logic [P+1:0]               push_item
);
  logic [P-1:0] hit;

  always_comb begin
    for (int i = 0; i < P; i++) begin
      hit[i] = (pat[i] == in_beat.text_char) || (pat[i] == wgm_pkg::ANY_CHAR);
    end
  end

  assign in_beat.ready = !qstat.full;
  assign push          = in_beat.valid && !qstat.full;
  assign push_item     = {hit, in_beat.last_char, in_beat.empty_text};
endmodule
`default_nettype wire

[design/wgm_queue.sv]
// Two-entry queue between the classifier and the position update.
// Depends on wgm_pkg for the status struct.
`default_nettype none
module wgm_queue #(
  parameter int unsigned W = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [W-1:0]         push_item,
  input  wire logic                 pop,
  output logic [W-1:0]              pop_item,
  output wgm_pkg::wgm_qstat_t       qstat
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign qstat.full  = (count_r == 2'd2);
  assign qstat.empty = (count_r == 2'd0);
  assign pop_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

[design/wgm_back.sv]
// Back end: star closure and advance of the active position set, result register.
// Depends on wgm_pkg, wgm_out_if and the queue status struct.
`default_nettype none
module wgm_back #(
  parameter int unsigned P = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [wgm_pkg::LEN_W-1:0]  eff_len,
  input  wire logic [P-1:0]               star,
  input  wire wgm_pkg::wgm_qstat_t        qstat,
  input  wire logic [P+1:0]               item,
  output logic                            pop,
  wgm_out_if.source                       out_beat
);
  logic [P:0]   active_r, active_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         matched_r, matched_nxt;
  logic         done_r, done_nxt;
  logic [P:0]   mask;
  logic [P:0]   set0;
  logic [P:0]   adv;
  logic [P:0]   set1;
  logic [P:0]   start;
  logic [P:0]   res;
  logic [P-1:0] hit;
  logic         last_c;
  logic         empty_c;

  // positions reachable through runs of stars
  function automatic logic [P:0] close_set(logic [P:0] s, logic [P-1:0] st);
    logic [P:0] c;
    logic       run;
    for (int k = 0; k <= P; k++) begin
      c[k] = s[k];
      run  = 1'b1;
      for (int j = k - 1; j >= 0; j--) begin
        run  = run & st[j];
        c[k] = c[k] | (s[j] & run);
      end
    end
    return c;
  endfunction

  assign {hit, last_c, empty_c} = item;
  assign pop = !qstat.empty && (!out_valid_r || out_beat.ready);

  always_comb begin
    for (int i = 0; i <= P; i++) begin
      mask[i] = (wgm_pkg::LEN_W'(i) <= eff_len);
    end
    set0 = close_set(active_r & mask, star);
    adv  = '0;
    for (int i = 0; i < P; i++) begin
      if (set0[i] && star[i]) begin
        adv[i] = 1'b1;
      end
      if (set0[i] && !star[i] && hit[i]) begin
        adv[i+1] = 1'b1;
      end
    end
    set1  = close_set(adv & mask, star);
    start = close_set((P+1)'(1), star);
    res   = empty_c ? start : set1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    matched_nxt   = matched_r;
    done_nxt      = done_r;
    active_nxt    = active_r;
    if (out_valid_r && out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      done_nxt      = empty_c || last_c;
      matched_nxt   = 1'b0;
      for (int i = 0; i <= P; i++) begin
        if (wgm_pkg::LEN_W'(i) == eff_len) begin
          matched_nxt = res[i];
        end
      end
      active_nxt = (empty_c || last_c) ? (P+1)'(1) : res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= (P+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
    done_r    <= done_nxt;
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.matched   = matched_r;
  assign out_beat.text_done = done_r;
endmodule
`default_nettype wire

[design/wgm_checker.sv]
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher and its stream interfaces.
`default_nettype none
module wgm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_matched,
  input wire logic out_text_done
);
  logic [2:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // beats taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_matched) && $stable(out_text_done))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a pending beat");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more beats in flight than storage");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 3'd0 |-> in_ready)
    else $error("input stalled while empty");
endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_beat.valid),
  .in_ready      (in_beat.ready),
  .out_valid     (out_beat.valid),
  .out_ready     (out_beat.ready),
  .out_matched   (out_beat.matched),
  .out_text_done (out_beat.text_done)
);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for wildcard_glob_matcher: streams texts against configured
// wildcard patterns and checks every result against an in-bench position-set predictor.
// Depends on wgm_pkg and the wgm_in_if / wgm_out_if stream interfaces.
module tb;
  localparam int unsigned PAT_MAX     = 16;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned RAND_PHASES = 24;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic [wgm_pkg::CHAR_W-1:0] text_char;
    logic                       last_char;
    logic                       empty_text;
  } char_beat_t;

  typedef struct packed {
    logic matched;
    logic text_done;
  } match_res_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_we;
  logic [wgm_pkg::IDX_W-1:0]    cfg_index;
  logic [wgm_pkg::WORD_W-1:0]   cfg_data;

  wgm_in_if  in_if ();
  wgm_out_if out_if ();

  wildcard_glob_matcher #(.PATTERN_MAX(PAT_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_beat   (in_if),
    .out_beat  (out_if)
  );

  // shadow of the pattern registers and the live position set
  logic [wgm_pkg::LEN_W-1:0]  pat_len = '0;
  logic [wgm_pkg::WORD_W-1:0] pat_words [4] = '{default: '0};
  logic [16:0]                pos_set = 17'd1;

  char_beat_t                 char_queue [$];
  match_res_t                 expected_matches [$];
  logic [wgm_pkg::CHAR_W-1:0] text_buf [$];
  int unsigned                phase_items;
  int unsigned                src_idle_pct;
  int unsigned                sink_idle_pct;
  int unsigned                fail_count = 0;
  int unsigned                quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_len();
    return (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
  endfunction

  function automatic logic [wgm_pkg::CHAR_W-1:0] pat_char(input int unsigned i);
    return pat_words[i >> 2][(i & 3) * 16 +: 16];
  endfunction

  function automatic logic [16:0] close_stars(input logic [16:0] s, input int unsigned n);
    logic [31:0] m;
    m = (32'd1 << (n + 1)) - 32'd1;
    s = s & m[16:0];
    for (int unsigned i = 0; i < n; i++)
      if (s[i] && pat_char(i) == wgm_pkg::STAR_CHAR) s[i + 1] = 1'b1;
    return s;
  endfunction

  function automatic logic [16:0] step_chars(input logic [16:0] s, input int unsigned n,
                                             input logic [wgm_pkg::CHAR_W-1:0] c);
    logic [16:0]                nx;
    logic [wgm_pkg::CHAR_W-1:0] p;
    nx = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (s[i]) begin
        p = pat_char(i);
        if (p == wgm_pkg::STAR_CHAR) nx[i] = 1'b1;
        else if (p == wgm_pkg::ANY_CHAR || p == c) nx[i + 1] = 1'b1;
      end
    end
    return nx;
  endfunction

  function automatic match_res_t predict_match(input char_beat_t b);
    int unsigned n;
    logic [16:0] s;
    match_res_t  r;
    n = eff_len();
    if (b.empty_text) begin
      s = close_stars(17'd1, n);
      r.text_done = 1'b1;
    end else begin
      s = close_stars(pos_set, n);
      s = close_stars(step_chars(s, n, b.text_char), n);
      r.text_done = b.last_char;
    end
    r.matched = s[n];
    pos_set = r.text_done ? 17'd1 : s;
    return r;
  endfunction

  function automatic logic [wgm_pkg::CHAR_W-1:0] rand_text_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'h0061 + 16'($urandom_range(3));
    if (r < 76) return ($urandom_range(1) != 0) ? wgm_pkg::STAR_CHAR : wgm_pkg::ANY_CHAR;
    if (r < 82) return '0;
    return wgm_pkg::CHAR_W'($urandom);
  endfunction

  function automatic logic [wgm_pkg::CHAR_W-1:0] rand_pat_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return wgm_pkg::STAR_CHAR;
    if (r < 40) return wgm_pkg::ANY_CHAR;
    if (r < 88) return 16'h0061 + 16'($urandom_range(2));
    return wgm_pkg::CHAR_W'($urandom);
  endfunction

  // driver: launches queued beats, predicts each accepted one
  always @(posedge clk) begin : driver
    char_beat_t nxt;
    char_beat_t took;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        took.text_char  = in_if.text_char;
        took.last_char  = in_if.last_char;
        took.empty_text = in_if.empty_text;
        expected_matches.push_back(predict_match(took));
      end
      if (!in_if.valid || in_if.ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = char_queue.pop_front();
          in_if.valid      <= 1'b1;
          in_if.text_char  <= nxt.text_char;
          in_if.last_char  <= nxt.last_char;
          in_if.empty_text <= nxt.empty_text;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result beat against the oldest prediction
  always @(posedge clk) begin : monitor
    match_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_matches.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: expected none, actual matched=%0b text_done=%0b",
                   $time, out_if.matched, out_if.text_done);
        end else begin
          want = expected_matches.pop_front();
          if (out_if.matched !== want.matched) begin
            fail_count++;
            $display("%0t: matched mismatch: expected %0b, actual %0b",
                     $time, want.matched, out_if.matched);
          end
          if (out_if.text_done !== want.text_done) begin
            fail_count++;
            $display("%0t: text_done mismatch: expected %0b, actual %0b",
                     $time, want.text_done, out_if.text_done);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [wgm_pkg::CHAR_W-1:0] c, input logic l, input logic e);
    char_beat_t b;
    b.text_char  = c;
    b.last_char  = l;
    b.empty_text = e;
    char_queue.push_back(b);
    phase_items++;
  endtask

  task automatic send_text(input bit finish);
    for (int i = 0; i < text_buf.size(); i++)
      send(text_buf[i], finish && (i == text_buf.size() - 1), 1'b0);
  endtask

  // block drained: no queued beats, nothing in flight, nothing expected
  task automatic settle();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_if.valid || expected_matches.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wgm_pkg::IDX_W-1:0] idx,
                           input logic [wgm_pkg::WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      wgm_pkg::CFG_LEN:    pat_len = data[wgm_pkg::LEN_W-1:0];
      wgm_pkg::CFG_WORD_A: pat_words[0] = data;
      wgm_pkg::CFG_WORD_B: pat_words[1] = data;
      wgm_pkg::CFG_WORD_C: pat_words[2] = data;
      wgm_pkg::CFG_WORD_D: pat_words[3] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_pattern(input logic [wgm_pkg::WORD_W-1:0] len_data,
                                 input logic [wgm_pkg::WORD_W-1:0] wa,
                                 input logic [wgm_pkg::WORD_W-1:0] wb,
                                 input logic [wgm_pkg::WORD_W-1:0] wc,
                                 input logic [wgm_pkg::WORD_W-1:0] wd,
                                 input bit spare);
    write_reg(wgm_pkg::CFG_LEN, len_data);
    write_reg(wgm_pkg::CFG_WORD_A, wa);
    write_reg(wgm_pkg::CFG_WORD_B, wb);
    write_reg(wgm_pkg::CFG_WORD_C, wc);
    write_reg(wgm_pkg::CFG_WORD_D, wd);
    if (spare)
      for (int k = wgm_pkg::CFG_WORD_D + 1; k < (1 << wgm_pkg::IDX_W); k++)
        write_reg(k[wgm_pkg::IDX_W-1:0], {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(negedge clk);
    phase_items = 0;
  endtask

  task automatic random_pattern();
    logic [wgm_pkg::WORD_W-1:0] w [4];
    logic [wgm_pkg::WORD_W-1:0] len_data;
    int unsigned                r;
    bit                         all_stars;
    r = $urandom_range(11);
    all_stars = (r == 3);
    for (int i = 0; i < 16; i++)
      w[i >> 2][(i & 3) * 16 +: 16] = all_stars ? wgm_pkg::STAR_CHAR : rand_pat_char();
    len_data = {$urandom, $urandom};
    case (r)
      0:       len_data[wgm_pkg::LEN_W-1:0] = '0;
      1:       len_data[wgm_pkg::LEN_W-1:0] = wgm_pkg::LEN_W'(PAT_MAX);
      2:       len_data[wgm_pkg::LEN_W-1:0] = wgm_pkg::LEN_W'($urandom_range(31, PAT_MAX + 1));
      default: len_data[wgm_pkg::LEN_W-1:0] = wgm_pkg::LEN_W'($urandom_range(PAT_MAX, 1));
    endcase
    program_pattern(len_data, w[0], w[1], w[2], w[3], $urandom_range(3) == 0);
  endtask

  task automatic fill_matching();
    int unsigned                n;
    int unsigned                k;
    logic [wgm_pkg::CHAR_W-1:0] p;
    text_buf.delete();
    n = eff_len();
    for (int unsigned i = 0; i < n; i++) begin
      p = pat_char(i);
      if (p == wgm_pkg::STAR_CHAR) repeat ($urandom_range(3)) text_buf.push_back(rand_text_char());
      else if (p == wgm_pkg::ANY_CHAR) text_buf.push_back(rand_text_char());
      else text_buf.push_back(p);
    end
    if (text_buf.size() != 0 && $urandom_range(99) < 30) begin
      k = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(2))
        0:       text_buf[k] = rand_text_char();
        1:       text_buf.delete(k);
        default: text_buf.insert(k, rand_text_char());
      endcase
    end
  endtask

  task automatic fill_noise();
    text_buf.delete();
    repeat ($urandom_range(8, 1)) text_buf.push_back(rand_text_char());
  endtask

  task automatic random_phase();
    int unsigned r;
    while (phase_items < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send(wgm_pkg::CHAR_W'($urandom), 1'($urandom), 1'b1);
      end else begin
        if (r < 80) fill_matching();
        else fill_noise();
        if (text_buf.size() == 0) send(wgm_pkg::CHAR_W'($urandom), 1'($urandom), 1'b1);
        else send_text(1'b1);
      end
    end
    // leave a text open so the next pattern change lands mid-text
    if ($urandom_range(1) != 0) begin
      fill_matching();
      if (text_buf.size() != 0) send_text(1'b0);
    end
  endtask

  initial begin : stimulus
    in_if.valid      = 1'b0;
    in_if.text_char  = '0;
    in_if.last_char  = 1'b0;
    in_if.empty_text = 1'b0;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = wgm_pkg::CFG_LEN;
    cfg_data         = '0;
    src_idle_pct     = 32;
    sink_idle_pct    = 56;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    phase_items = 0;

    // reset pattern is empty: only the empty text matches
    send(16'h0000, 1'b0, 1'b1);
    send(16'h0061, 1'b1, 1'b0);
    send(16'h0000, 1'b0, 1'b0);
    send(16'hFFFF, 1'b1, 1'b0);

    // oversized length saturates; zero and all-ones pattern characters
    settle();
    program_pattern(64'h1F,
                    {wgm_pkg::STAR_CHAR, 16'hFFFF, 16'h0000, wgm_pkg::ANY_CHAR},
                    {16'h0062, wgm_pkg::STAR_CHAR, wgm_pkg::STAR_CHAR, 16'h0061},
                    {wgm_pkg::STAR_CHAR, 16'h0063, wgm_pkg::ANY_CHAR, wgm_pkg::ANY_CHAR},
                    {wgm_pkg::STAR_CHAR, wgm_pkg::STAR_CHAR, 16'h0065, 16'h0064}, 1'b1);
    send(16'h1234, 1'b0, 1'b0);
    send(16'h0000, 1'b1, 1'b1);
    send(16'h0000, 1'b0, 1'b0);
    send(16'h0000, 1'b0, 1'b0);
    send(16'hFFFF, 1'b0, 1'b0);
    send(16'h0078, 1'b0, 1'b0);
    send(16'h0061, 1'b0, 1'b0);
    send(16'h0079, 1'b0, 1'b0);
    send(16'h0062, 1'b0, 1'b0);
    send(16'h0071, 1'b0, 1'b0);
    send(16'h0000, 1'b0, 1'b0);
    send(16'h0063, 1'b0, 1'b0);
    send(16'h0064, 1'b0, 1'b0);
    send(16'h0065, 1'b1, 1'b0);
    send(16'h0000, 1'b0, 1'b1);

    // all stars, then a pattern swap while that text is still open
    settle();
    program_pattern(64'd16, {4{wgm_pkg::STAR_CHAR}}, {4{wgm_pkg::STAR_CHAR}},
                    {4{wgm_pkg::STAR_CHAR}}, {4{wgm_pkg::STAR_CHAR}}, 1'b0);
    send(16'h0000, 1'b0, 1'b1);
    send(16'h007A, 1'b0, 1'b0);
    send(16'hFFFF, 1'b0, 1'b0);
    settle();
    program_pattern(64'd16, '1, '1, '1, '1, 1'b0);
    send(16'hFFFF, 1'b1, 1'b0);
    send(16'hFFFF, 1'b1, 1'b1);

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      random_pattern();
      if (ph == RAND_PHASES / 3) begin
        src_idle_pct  = 56;
        sink_idle_pct = 32;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      random_phase();
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
